>>> rtl/core/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg - shared definitions for the pivot point detector
// Field widths, register indexes, reset values and the types that pass
// between the window cells, the evaluator and the top level.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int PPD_MAX_SIDE = 31;
	localparam int SAMPLE_W     = 32;
	localparam int CFG_W        = 5;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPAN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPAN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIND_LOW   = 2'd2;

	localparam logic [CFG_W-1:0] LEFT_SPAN_RST  = 5'd2;
	localparam logic [CFG_W-1:0] RIGHT_SPAN_RST = 5'd2;

	// one window slot: valid flag and sample
	typedef struct packed {
		logic                       ok;
		logic signed [SAMPLE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic main_we;    // take the upstream value into the window slot
		logic scan_load;  // copy the updated slot into the scan register
		logic scan_shift; // move the scan register one cell towards the head
	} cell_ctl_t;

endpackage

>>> rtl/core/ppd_sample_if.sv
// ----------------------------------------------------------------------------
// ppd_sample_if - sample channel
// Valid/ready channel carrying one bar sample, its valid flag and the
// rewrite flag.
// ----------------------------------------------------------------------------
interface ppd_sample_if;
	import ppd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       sample_valid;
	logic                       rewrite;

	modport source (output valid, output sample, output sample_valid, output rewrite,
		input ready);
	modport sink (input valid, input sample, input sample_valid, input rewrite,
		output ready);

endinterface

>>> rtl/core/ppd_pivot_if.sv
// ----------------------------------------------------------------------------
// ppd_pivot_if - pivot result channel
// Valid/ready channel carrying the pivot flag and the pivot sample.
// ----------------------------------------------------------------------------
interface ppd_pivot_if;
	import ppd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       pivot_found;
	logic signed [SAMPLE_W-1:0] pivot_value;

	modport source (output valid, output pivot_found, output pivot_value, input ready);
	modport sink (input valid, input pivot_found, input pivot_value, output ready);

endinterface

>>> rtl/core/pivot_point_detector_core.sv
// ----------------------------------------------------------------------------
// pivot_point_detector_core - pivot high / pivot low detector
// Bar samples enter on the samples channel; one result per sample leaves on
// the pivots channel. Spans and mode are set through the register port.
//
// A transaction on samples either pushes a new bar or, with rewrite set and
// the window not empty, replaces the newest bar. The window is a row of
// 2*MAX_SIDE+1 cells, newest first. On acceptance the updated row is copied
// into a scan line that moves one cell per cycle past the evaluator, which
// steps over every held bar (left+right+1 once the window is full), then
// registers the result. No new sample is taken until the scan is through
// and the result register has taken the result.
// The result register lets the next sample be taken and scanned while an
// earlier result still waits; if pivots stalls, the finished result holds
// and samples.ready stays low until the register frees.
// Reset empties the window (fill count zero), restores left/right spans of
// 2 and high mode, and drops any pending result. Stored samples are not
// cleared; entries beyond the fill count are never evaluated.
// ----------------------------------------------------------------------------
module pivot_point_detector_core #(
	parameter int MAX_SIDE = ppd_pkg::PPD_MAX_SIDE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ppd_sample_if.sink                     samples,
	ppd_pivot_if.source                    pivots,
	input  logic                           cfg_we,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ppd_pkg::CFG_W-1:0]      cfg_data
);
	import ppd_pkg::*;

	localparam int DEPTH = 2 * MAX_SIDE + 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SAT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [SAT_W-1:0] SIDE_MAX = SAT_W'(MAX_SIDE);

	logic [CFG_W-1:0] left_q;
	logic [CFG_W-1:0] right_q;
	logic             find_low_q;
	logic [CNT_W-1:0] fill_q;

	logic [SAT_W-1:0] left_w;
	logic [SAT_W-1:0] right_w;
	logic [CNT_W-1:0] l_sat;
	logic [CNT_W-1:0] r_sat;
	logic [CNT_W-1:0] total;
	logic [CNT_W-1:0] fill_n;
	logic [CNT_W-1:0] base;
	logic [CNT_W-1:0] cand_pos;
	logic             span_ok;
	logic             accept;
	logic             push;
	logic             scan_shift;
	entry_t           new_entry;

	entry_t    main_out [DEPTH];
	entry_t    scan_out [DEPTH];
	cell_ctl_t ctl      [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= LEFT_SPAN_RST;
			right_q    <= RIGHT_SPAN_RST;
			find_low_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_SPAN:  left_q     <= cfg_data;
				REG_RIGHT_SPAN: right_q    <= cfg_data;
				REG_FIND_LOW:   find_low_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// spans saturate at MAX_SIDE
	assign left_w  = SAT_W'(left_q);
	assign right_w = SAT_W'(right_q);
	assign l_sat   = CNT_W'((left_w > SIDE_MAX) ? SIDE_MAX : left_w);
	assign r_sat   = CNT_W'((right_w > SIDE_MAX) ? SIDE_MAX : right_w);
	assign total   = CNT_W'(l_sat + r_sat + 1'b1);

	assign accept    = samples.valid && samples.ready;
	assign push      = !(samples.rewrite && (fill_q != '0));
	assign new_entry = '{ok: samples.sample_valid, value: samples.sample};

	// a push keeps the newest span's worth of bars
	assign fill_n   = !push ? fill_q : ((fill_q >= total) ? total : CNT_W'(fill_q + 1'b1));
	assign span_ok  = (fill_n >= total);
	assign base     = CNT_W'(fill_n - total);
	assign cand_pos = CNT_W'(fill_n - 1'b1 - l_sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_n;
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		entry_t main_in;
		entry_t scan_in;

		if (k == 0) begin : g_head
			assign ctl[k].main_we = accept;
			assign main_in        = new_entry;
		end else begin : g_body
			assign ctl[k].main_we = accept && push;
			assign main_in        = main_out[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign scan_in = scan_out[k];
		end else begin : g_link
			assign scan_in = scan_out[k+1];
		end

		assign ctl[k].scan_load  = accept;
		assign ctl[k].scan_shift = scan_shift;

		ppd_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[k]),
			.main_in  (main_in),
			.scan_in  (scan_in),
			.main_out (main_out[k]),
			.scan_out (scan_out[k])
		);
	end

	ppd_eval #(
		.CNT_W (CNT_W)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.fill_n     (fill_n),
		.base       (base),
		.cand_pos   (cand_pos),
		.span_ok    (span_ok),
		.find_low   (find_low_q),
		.head       (scan_out[0]),
		.in_ready   (samples.ready),
		.scan_shift (scan_shift),
		.out_valid  (pivots.valid),
		.out_ready  (pivots.ready),
		.out_found  (pivots.pivot_found),
		.out_value  (pivots.pivot_value)
	);

endmodule

>>> rtl/core/ppd_cell.sv
// ----------------------------------------------------------------------------
// ppd_cell - one window slot
// Holds one stored sample, newest-first position fixed by its place in the
// row, plus a scan register that is loaded from the slot and then passed
// towards the head of the row one cell per cycle.
// ----------------------------------------------------------------------------
module ppd_cell (
	input  logic                clk,
	input  ppd_pkg::cell_ctl_t  ctl,
	input  ppd_pkg::entry_t     main_in,
	input  ppd_pkg::entry_t     scan_in,
	output ppd_pkg::entry_t     main_out,
	output ppd_pkg::entry_t     scan_out
);
	import ppd_pkg::*;

	entry_t main_q;
	entry_t scan_q;
	entry_t main_d;

	assign main_d = ctl.main_we ? main_in : main_q;

	always_ff @(posedge clk) begin
		main_q <= main_d;
		if (ctl.scan_load) begin
			scan_q <= main_d;
		end else if (ctl.scan_shift) begin
			scan_q <= scan_in;
		end
	end

	assign main_out = main_q;
	assign scan_out = scan_q;

endmodule

>>> rtl/core/ppd_eval.sv
// ----------------------------------------------------------------------------
// ppd_eval - scan sequencer and pivot evaluator
// Watches the head of the scan row as positions go by newest first, keeps
// the extreme of the newer side, checks the candidate against it, then the
// older side against the candidate. Holds the result register.
// ----------------------------------------------------------------------------
module ppd_eval #(
	parameter int CNT_W = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [CNT_W-1:0]                    fill_n,
	input  logic [CNT_W-1:0]                    base,
	input  logic [CNT_W-1:0]                    cand_pos,
	input  logic                                span_ok,
	input  logic                                find_low,
	input  ppd_pkg::entry_t                     head,
	output logic                                in_ready,
	output logic                                scan_shift,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_found,
	output logic signed [ppd_pkg::SAMPLE_W-1:0] out_value
);
	import ppd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           t_q;
	logic [CNT_W-1:0]           last_q;
	logic [CNT_W-1:0]           base_q;
	logic [CNT_W-1:0]           cpos_q;
	logic                       ok_q;
	logic                       have_newer_q;
	logic signed [SAMPLE_W-1:0] ext_q;
	logic signed [SAMPLE_W-1:0] cand_q;
	logic                       out_valid_q;
	logic                       out_found_q;
	logic signed [SAMPLE_W-1:0] out_value_q;

	logic                       is_newer;
	logic                       is_cand;
	logic                       is_older;
	logic signed [SAMPLE_W-1:0] ref_v;
	logic                       better;
	logic                       step_ok;
	logic                       out_free;
	logic                       scanning;

	assign scanning = (state_q == ST_SCAN);
	assign is_cand  = (t_q == cpos_q);
	assign is_older = (t_q > cpos_q);
	assign is_newer = (t_q >= base_q) && (t_q < cpos_q);

	// one comparator: newer side and candidate against running extreme, older against candidate
	assign ref_v  = is_older ? cand_q : ext_q;
	assign better = find_low ? (head.value < ref_v) : (head.value > ref_v);

	always_comb begin
		step_ok = 1'b1;
		if (is_cand) begin
			step_ok = head.ok && (!have_newer_q || better);
		end else if (is_older) begin
			step_ok = head.ok && !better;
		end else if (is_newer) begin
			step_ok = head.ok;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (t_q == last_q) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			t_q          <= '0;
			last_q       <= fill_n - 1'b1;
			base_q       <= base;
			cpos_q       <= cand_pos;
			ok_q         <= span_ok;
			have_newer_q <= 1'b0;
		end else if (scanning) begin
			t_q  <= CNT_W'(t_q + 1'b1);
			ok_q <= ok_q && step_ok;
			if (is_cand) begin
				cand_q <= head.value;
			end
			if (is_newer && (!have_newer_q || better)) begin
				ext_q        <= head.value;
				have_newer_q <= 1'b1;
			end
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_found_q <= ok_q;
			out_value_q <= ok_q ? cand_q : '0;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign scan_shift = scanning;
	assign out_valid  = out_valid_q;
	assign out_found  = out_found_q;
	assign out_value  = out_value_q;

endmodule

>>> rtl/core/ppd_checker.sv
// ----------------------------------------------------------------------------
// ppd_checker - port-level checks for the pivot point detector
// Watches the channel ports of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module ppd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                out_found,
	input logic signed [ppd_pkg::SAMPLE_W-1:0] out_value
);

	// one sample at a time: the channel closes after each transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample taken while previous one still in work");

	// a result needs the scan; none appears right after a sample is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared without a scan");

	a_no_pivot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_found) |-> (out_value == '0))
		else $error("non-zero value without a pivot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_value)))
		else $error("stalled result changed");

endmodule

bind pivot_point_detector_core ppd_checker u_ppd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (pivots.valid),
	.out_ready (pivots.ready),
	.out_found (pivots.pivot_found),
	.out_value (pivots.pivot_value)
);

>>> tb/tb_pivot_point_detector_core.sv
// ----------------------------------------------------------------------------
// tb_pivot_point_detector_core - self-checking bench for the pivot detector
// Streams bar samples through the valid/ready channels with random gaps and
// stalls, predicts each pivot result from a local copy of the window and the
// span registers, and compares every result transaction in order. Spans and
// mode are changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_pivot_point_detector_core;
	import ppd_pkg::*;

	localparam int WINDOW_DEPTH = 2 * PPD_MAX_SIDE + 1;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TAIL_CYCLES  = 2 * PPD_MAX_SIDE + 8;
	localparam int PHASES       = 16;
	localparam int PHASE_BARS   = 118;
	// index past the register list, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       ok;
		logic                       rewrite;
	} bar_t;

	typedef struct packed {
		logic                       found;
		logic signed [SAMPLE_W-1:0] value;
	} pivot_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ppd_sample_if samples_if ();
	ppd_pivot_if  pivots_if ();

	pivot_point_detector_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.pivots    (pivots_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bar_t   bar_pending_q[$];
	pivot_t pivot_expected_q[$];
	entry_t held_bars[$];

	logic [CFG_W-1:0] left_span_q;
	logic [CFG_W-1:0] right_span_q;
	logic             low_mode_q;

	int   cycle_count;
	int   fail_count;
	logic gaps_on;

	assign gaps_on = !(cycle_count >= 3000 && cycle_count < 9000);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// window update and pivot evaluation for one accepted bar
	function automatic pivot_t predict_pivot(bar_t b);
		entry_t           e;
		pivot_t           res;
		int               l;
		int               total;
		int               i;
		logic             hit;
		logic signed [SAMPLE_W-1:0] cand;
		e.ok    = b.ok;
		e.value = b.sample;
		l       = int'(left_span_q);
		total   = l + int'(right_span_q) + 1;
		if (b.rewrite && held_bars.size() > 0) begin
			held_bars[held_bars.size() - 1] = e;
		end else begin
			if (held_bars.size() >= WINDOW_DEPTH)
				held_bars.delete(0);
			held_bars.insert(held_bars.size(), e);
			while (held_bars.size() > total)
				held_bars.delete(0);
		end
		hit  = 1'b0;
		cand = '0;
		if (held_bars.size() >= total) begin
			hit  = held_bars[l].ok;
			cand = held_bars[l].value;
		end
		if (hit) begin
			for (i = 0; i < total; i++) begin
				if (i == l)
					continue;
				if (!held_bars[i].ok)
					hit = 1'b0;
				else if (i < l) begin
					// ties allowed on the older side
					if (low_mode_q ? (held_bars[i].value < cand) : (held_bars[i].value > cand))
						hit = 1'b0;
				end else if (low_mode_q ? (held_bars[i].value <= cand)
						: (held_bars[i].value >= cand)) begin
					hit = 1'b0;
				end
			end
		end
		res.found = hit;
		res.value = hit ? cand : '0;
		return res;
	endfunction

	task automatic add_bar(logic signed [SAMPLE_W-1:0] v, logic ok, logic rw);
		bar_t b;
		b.sample  = v;
		b.ok      = ok;
		b.rewrite = rw;
		bar_pending_q.insert(bar_pending_q.size(), b);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (bar_pending_q.size() != 0 || samples_if.valid || pivot_expected_q.size() != 0)
			@(negedge clk);
	endtask

	// mostly pivot-shaped runs with random content, the rest noise
	task automatic queue_phase(int n, int l, int r, logic low);
		int                         cnt;
		int                         k;
		int                         d;
		logic signed [SAMPLE_W-1:0] peak;
		logic signed [SAMPLE_W-1:0] v;
		cnt = 1;
		add_bar($urandom, 1'b1, 1'b1);
		while (cnt < n) begin
			if ($urandom_range(99) < 65) begin
				case ($urandom_range(9))
					0:       peak = 32'h7FFF_FFFF;
					1:       peak = 32'h8000_0000;
					default: peak = $urandom;
				endcase
				for (k = 0; k < l + r + 1; k++) begin
					if (k < l)
						d = $urandom_range(0, 40);
					else if (k > l)
						d = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 40);
					else
						d = 0;
					v = low ? peak + d : peak - d;
					add_bar(v, $urandom_range(99) >= 2, $urandom_range(99) < 4);
				end
				cnt += l + r + 1;
			end else begin
				for (k = $urandom_range(1, 4); k > 0; k--) begin
					v = ($urandom_range(1) == 0) ? $urandom : $signed($urandom_range(0, 15));
					add_bar(v, $urandom_range(99) >= 15, $urandom_range(99) < 15);
					cnt++;
				end
			end
		end
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin : drive_samples
		bar_t nxt;
		if (!arst_n) begin
			samples_if.valid        <= 1'b0;
			samples_if.sample       <= '0;
			samples_if.sample_valid <= 1'b0;
			samples_if.rewrite      <= 1'b0;
		end else if (!samples_if.valid || samples_if.ready) begin
			if (bar_pending_q.size() > 0 && !(gaps_on && $urandom_range(99) < 6)) begin
				nxt = bar_pending_q[0];
				bar_pending_q.delete(0);
				samples_if.valid        <= 1'b1;
				samples_if.sample       <= nxt.sample;
				samples_if.sample_valid <= nxt.ok;
				samples_if.rewrite      <= nxt.rewrite;
			end else begin
				samples_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pivots_if.ready <= 1'b0;
		else
			pivots_if.ready <= !(gaps_on && $urandom_range(99) < 6);
	end

	// monitor: register copies, predictions and in-order comparison
	always @(posedge clk) begin : check_pivots
		pivot_t want;
		bar_t   got_bar;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEFT_SPAN:  left_span_q  = cfg_data;
					REG_RIGHT_SPAN: right_span_q = cfg_data;
					REG_FIND_LOW:   low_mode_q   = cfg_data[0];
					default: ;
				endcase
			end
			if (pivots_if.valid && pivots_if.ready) begin
				if (pivot_expected_q.size() == 0) begin
					$display("%0t: unexpected pivot transaction found %0b value %0d", $time,
						pivots_if.pivot_found, pivots_if.pivot_value);
					fail_count++;
				end else begin
					want = pivot_expected_q[0];
					pivot_expected_q.delete(0);
					if (pivots_if.pivot_found !== want.found) begin
						$display("%0t: pivot_found expected %0b actual %0b", $time,
							want.found, pivots_if.pivot_found);
						fail_count++;
					end
					if (pivots_if.pivot_value !== want.value) begin
						$display("%0t: pivot_value expected %0d actual %0d", $time,
							want.value, pivots_if.pivot_value);
						fail_count++;
					end
				end
			end
			if (samples_if.valid && samples_if.ready) begin
				got_bar.sample  = samples_if.sample;
				got_bar.ok      = samples_if.sample_valid;
				got_bar.rewrite = samples_if.rewrite;
				pivot_expected_q.insert(pivot_expected_q.size(), predict_pivot(got_bar));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pivot_expected_q.size());
			$display("** pivot_point_detector_core: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int          p;
		int          l;
		int          r;
		logic        low;
		int          preset_l[8];
		int          preset_r[8];
		logic        preset_low[8];
		preset_l   = '{2, 0, 0, 31, 31, 0, 31, 1};
		preset_r   = '{2, 0, 0, 31, 31, 31, 0, 1};
		preset_low = '{0, 1, 0, 0, 1, 0, 1, 1};
		cycle_count  = 0;
		fail_count   = 0;
		left_span_q  = LEFT_SPAN_RST;
		right_span_q = RIGHT_SPAN_RST;
		low_mode_q   = 1'b0;
		arst_n       = 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset spans 2/2, high mode
		@(negedge clk);
		add_bar(10, 1'b1, 1'b1);          // rewrite into an empty window
		add_bar(20, 1'b1, 1'b0);
		add_bar(50, 1'b1, 1'b0);
		add_bar(30, 1'b1, 1'b0);
		add_bar(40, 1'b1, 1'b0);          // first full window, clear pivot
		add_bar(49, 1'b1, 1'b1);
		add_bar(50, 1'b1, 1'b1);          // newer tie rejects
		add_bar(7, 1'b1, 1'b0);
		add_bar(100, 1'b1, 1'b0);
		add_bar(100, 1'b1, 1'b0);
		add_bar(100, 1'b1, 1'b0);         // older ties accepted
		add_bar(99, 1'b1, 1'b0);
		add_bar(98, 1'b1, 1'b0);
		add_bar(100, 1'b1, 1'b0);
		add_bar(100, 1'b1, 1'b0);
		add_bar(200, 1'b0, 1'b0);         // missing candidate
		add_bar(1, 1'b1, 1'b0);
		add_bar(1, 1'b1, 1'b0);
		add_bar(32'h8000_0000, 1'b1, 1'b0);
		add_bar(32'h8000_0000, 1'b1, 1'b0);
		add_bar(32'h7FFF_FFFF, 1'b1, 1'b0);
		add_bar(32'h8000_0000, 1'b1, 1'b0);
		add_bar(32'h8000_0000, 1'b1, 1'b0);
		add_bar(32'h7FFF_FFFF, 1'b0, 1'b0);
		wait_drained();
		write_reg(REG_UNUSED, 5'h1F);

		for (p = 0; p < PHASES; p++) begin
			if (p < 8) begin
				l   = preset_l[p];
				r   = preset_r[p];
				low = preset_low[p];
			end else begin
				l   = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
				r   = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
				low = $urandom_range(1);
			end
			write_reg(REG_LEFT_SPAN, CFG_W'(l));
			write_reg(REG_RIGHT_SPAN, CFG_W'(r));
			write_reg(REG_FIND_LOW, {4'($urandom_range(0, 15)), low});
			@(negedge clk);
			if (p % 2 == 1) begin
				// hold off mid-phase until every result is back
				queue_phase(PHASE_BARS / 2, l, r, low);
				wait_drained();
				queue_phase(PHASE_BARS - PHASE_BARS / 2, l, r, low);
			end else begin
				queue_phase(PHASE_BARS, l, r, low);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pivot_expected_q.size() == 0) begin
			$display("** pivot_point_detector_core: PASSED **");
		end else begin
			$display("** pivot_point_detector_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/ppd_pkg.sv
rtl/core/ppd_sample_if.sv
rtl/core/ppd_pivot_if.sv
rtl/core/ppd_cell.sv
rtl/core/ppd_eval.sv
rtl/core/pivot_point_detector_core.sv
rtl/core/ppd_checker.sv
tb/tb_pivot_point_detector_core.sv
